### rtl/dcp_pkg.sv
// Shared constants and types for the descriptor chain pool.
package dcp_pkg;

  localparam int POOL_SIZE_DEFAULT = 8;
  localparam int CHAIN_LEN         = 3;
  localparam int LINK_W            = 3;
  localparam int HEAD_W            = 4;
  localparam int STATUS_W          = 3;
  localparam int COUNT_W           = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_RANGE   = 3'd2,
    ST_DOUBLE  = 3'd3,
    ST_TOOLONG = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

endpackage

### rtl/dcp_req_if.sv
// Request channel: opcode and head index with valid/ready handshake.
interface dcp_req_if
  import dcp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [HEAD_W-1:0] head_index;

  modport source (output valid, opcode, head_index, input ready);
  modport sink   (input valid, opcode, head_index, output ready);
endinterface

### rtl/dcp_rsp_if.sv
// Response channel: status, allocated entries and counts with valid/ready handshake.
interface dcp_rsp_if
  import dcp_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LINK_W-1:0]   first_entry;
  logic [LINK_W-1:0]   second_entry;
  logic [LINK_W-1:0]   third_entry;
  logic [COUNT_W-1:0]  freed_count;
  logic [COUNT_W-1:0]  in_use_count;
  logic [COUNT_W-1:0]  peak_in_use;

  modport source (output valid, status, first_entry, second_entry, third_entry,
                  freed_count, in_use_count, peak_in_use, input ready);
  modport sink   (input valid, status, first_entry, second_entry, third_entry,
                  freed_count, in_use_count, peak_in_use, output ready);
endinterface

### rtl/dcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/descriptor_chain_pool.sv
// Descriptor chain pool: free map, per-entry links and a small sequencer.
//
// The pool holds POOL_SIZE descriptors. Each entry has a free bit and a
// has-next flag in flip-flops, and a 3-bit next link in a small RAM with a
// registered read port. After an allocate request is transferred, a single
// lowest-set-bit picker finds one free entry per cycle for each of the three picks;
// the links first->second->third are written into the
// link RAM as the picks arrive, and the free map, has-next flags and in-use
// count are only committed once the third pick is found, so a request that
// finds fewer than three free entries changes nothing but the peak sample
// and reports no space. A free request walks the chain from head_index
// link by link: the check state tests range and the free bit, releases the
// entry and reads its link, and the follow state takes the registered link
// data. The walk stops with out of range, already free, or chain too long.
// The done state then moves the result into the output register; the
// registered link RAM read sets the walk rate. The sequencer returns to
// idle as the result is loaded. The block takes no new request while one
// is in progress, but it does accept the next request while a finished
// result still waits in the output register; the result of that next
// request is held until the earlier one has been transferred, and the
// sequencer waits in its done state meanwhile. in_use_count and peak_in_use
// are reported modulo 16; the peak is sampled from the count before each
// allocate request, successful or not.
module descriptor_chain_pool
  import dcp_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  dcp_req_if.sink      req,
  dcp_rsp_if.source    rsp
);

  localparam int IDX_W  = $clog2(POOL_SIZE);
  // wide enough for the head index, a link and the value POOL_SIZE itself
  localparam int EXT_W  = (IDX_W + 1 > HEAD_W) ? IDX_W + 1 : HEAD_W;
  // in-use, peak and freed counts; wide enough to hold POOL_SIZE + 1
  localparam int CNT_W  = ($clog2(POOL_SIZE + 2) > COUNT_W) ? $clog2(POOL_SIZE + 2) : COUNT_W;
  localparam logic [EXT_W-1:0] POOL_LIM = EXT_W'(POOL_SIZE);
  localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);
  localparam logic [CNT_W-1:0] CHAIN_CNT = CNT_W'(CHAIN_LEN);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PICK   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_FOLLOW = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t               state;
  logic [POOL_SIZE-1:0] free_map;
  logic [POOL_SIZE-1:0] has_next;
  logic [CNT_W-1:0]     busy;
  logic [CNT_W-1:0]     peak;

  // per-request working registers
  logic [POOL_SIZE-1:0] scan_map;
  logic [1:0]           pick_cnt;
  logic [IDX_W-1:0]     pick0;
  logic [IDX_W-1:0]     pick1;
  logic [LINK_W-1:0]    link0;
  logic [LINK_W-1:0]    link1;
  logic [HEAD_W-1:0]    cur;
  logic [CNT_W-1:0]     freed;
  status_t              res_status;
  logic [LINK_W-1:0]    res_first;
  logic [LINK_W-1:0]    res_second;
  logic [LINK_W-1:0]    res_third;

  // output register
  logic                 out_valid;
  status_t              out_status;
  logic [LINK_W-1:0]    out_first;
  logic [LINK_W-1:0]    out_second;
  logic [LINK_W-1:0]    out_third;
  logic [COUNT_W-1:0]   out_freed;
  logic [COUNT_W-1:0]   out_busy;
  logic [COUNT_W-1:0]   out_peak;

  // shared picker and walk decode
  logic                 pick_hit;
  logic [IDX_W-1:0]     pick_idx;
  logic [EXT_W-1:0]     pick_ext;
  logic [LINK_W-1:0]    pick_link;
  logic [POOL_SIZE-1:0] pick_bit;
  logic [POOL_SIZE-1:0] chain_bits;
  logic [EXT_W-1:0]     cur_ext;
  logic [IDX_W-1:0]     cur_idx;
  logic                 cur_in_range;
  logic                 out_free;

  // link RAM
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [LINK_W-1:0]    ram_wdata;
  logic [LINK_W-1:0]    ram_rdata;

  // Lowest free entry not yet taken by this request.
  always_comb begin
    pick_hit = 1'b0;
    pick_idx = '0;
    for (int k = POOL_SIZE - 1; k >= 0; k--) begin
      if (scan_map[k]) begin
        pick_hit = 1'b1;
        pick_idx = IDX_W'(k);
      end
    end
    pick_ext  = EXT_W'(pick_idx);
    pick_link = pick_ext[LINK_W-1:0];
  end

  // one-hot of the current pick, and of the first two picks of the chain
  assign pick_bit     = POOL_SIZE'(1) << pick_idx;
  assign chain_bits   = (POOL_SIZE'(1) << pick0) | (POOL_SIZE'(1) << pick1);

  assign cur_ext      = EXT_W'(cur);
  assign cur_idx      = cur_ext[IDX_W-1:0];
  assign cur_in_range = (cur_ext < POOL_LIM);
  assign out_free     = !out_valid || rsp.ready;

  // Write each link as soon as its successor is known; it only becomes
  // visible once has-next is set at commit.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pick0;
    ram_wdata = pick_link;
    if (state == S_PICK && pick_hit) begin
      case (pick_cnt)
        2'd1: begin
          ram_we    = 1'b1;
          ram_waddr = pick0;
        end
        2'd2: begin
          ram_we    = 1'b1;
          ram_waddr = pick1;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  dcp_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_SIZE)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_idx),
    .rdata (ram_rdata)
  );

  // Sequencer and pool state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_map  <= '1;
      has_next  <= '0;
      busy      <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new result, or drop the one just transferred
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_status <= ST_OK;
            res_first  <= '0;
            res_second <= '0;
            res_third  <= '0;
            freed      <= '0;
            if (opcode_t'(req.opcode) == OP_ALLOC) begin
              if (busy > peak) begin
                peak <= busy;
              end
              scan_map <= free_map;
              pick_cnt <= '0;
              state    <= S_PICK;
            end else begin
              cur   <= req.head_index;
              state <= S_CHECK;
            end
          end
        end

        S_PICK: begin
          if (!pick_hit) begin
            res_status <= ST_NOSPACE;
            state      <= S_DONE;
          end else begin
            scan_map <= scan_map & ~pick_bit;
            case (pick_cnt)
              2'd0: begin
                pick0    <= pick_idx;
                link0    <= pick_link;
                pick_cnt <= 2'd1;
              end
              2'd1: begin
                pick1    <= pick_idx;
                link1    <= pick_link;
                pick_cnt <= 2'd2;
              end
              default: begin
                // third entry found: commit the chain
                free_map   <= free_map & ~(chain_bits | pick_bit);
                has_next   <= (has_next | chain_bits) & ~pick_bit;
                busy       <= busy + CHAIN_CNT;
                res_first  <= link0;
                res_second <= link1;
                res_third  <= pick_link;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_CHECK: begin
          if (!cur_in_range) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else if (free_map[cur_idx]) begin
            res_status <= ST_DOUBLE;
            state      <= S_DONE;
          end else begin
            // release the entry; its link arrives from the RAM next cycle
            free_map[cur_idx] <= 1'b1;
            has_next[cur_idx] <= 1'b0;
            if (busy != '0) begin
              busy <= busy - CNT_W'(1);
            end
            freed <= freed + CNT_W'(1);
            state <= has_next[cur_idx] ? S_FOLLOW : S_DONE;
          end
        end

        S_FOLLOW: begin
          cur <= HEAD_W'(ram_rdata);
          if (freed > POOL_CNT) begin
            res_status <= ST_TOOLONG;
            state      <= S_DONE;
          end else begin
            state <= S_CHECK;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_status <= res_status;
            out_first  <= res_first;
            out_second <= res_second;
            out_third  <= res_third;
            out_freed  <= freed[COUNT_W-1:0];
            out_busy   <= busy[COUNT_W-1:0];
            out_peak   <= peak[COUNT_W-1:0];
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE) && !rst;

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.first_entry  = out_first;
  assign rsp.second_entry = out_second;
  assign rsp.third_entry  = out_third;
  assign rsp.freed_count  = out_freed;
  assign rsp.in_use_count = out_busy;
  assign rsp.peak_in_use  = out_peak;

endmodule

### bench/descriptor_chain_pool_tb.sv
// Self-checking testbench for the descriptor chain pool: directed, back-pressure and random traffic.
module descriptor_chain_pool_tb
  import dcp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_ENTRIES = POOL_SIZE_DEFAULT;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE       = 24;

  // One reply of the block, field by field at port widths.
  typedef struct packed {
    status_t            status;
    logic [LINK_W-1:0]  first_entry;
    logic [LINK_W-1:0]  second_entry;
    logic [LINK_W-1:0]  third_entry;
    logic [COUNT_W-1:0] freed_count;
    logic [COUNT_W-1:0] in_use_count;
    logic [COUNT_W-1:0] peak_in_use;
  } pool_reply_t;

  logic clk;
  logic rst;

  dcp_req_if req ();
  dcp_rsp_if rsp ();

  descriptor_chain_pool #(
    .POOL_SIZE(POOL_ENTRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // Shadow copy of the pool, advanced once per accepted request.
  bit                 shadow_free [POOL_ENTRIES];
  logic [LINK_W-1:0]  shadow_link [POOL_ENTRIES];
  bit                 shadow_more [POOL_ENTRIES];
  int                 shadow_in_use;
  int                 shadow_peak;

  pool_reply_t        replies_due [$];
  logic [LINK_W-1:0]  live_heads [$];
  int                 mismatches;
  int                 cycle_count = 0;
  bit                 gaps_on;
  bit                 hold_request;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("descriptor_chain_pool regression: fail");
      $finish;
    end
  end

  // Work out the reply to one request and advance the shadow pool with it.
  // Allocation samples the peak before it picks, whether or not it succeeds;
  // a free walks the links until the chain ends or an error stops it.
  function automatic pool_reply_t pool_reply(opcode_t op, logic [HEAD_W-1:0] head);
    pool_reply_t       r;
    int                picks [CHAIN_LEN];
    int                found;
    int                cur;
    int                freed;
    bit                more;
    bit                done;
    logic [LINK_W-1:0] nxt;
    r = '0;
    r.status = ST_OK;
    freed = 0;
    if (op == OP_ALLOC) begin
      if (shadow_in_use > shadow_peak) shadow_peak = shadow_in_use;
      found = 0;
      for (int k = 0; k < POOL_ENTRIES; k++) begin
        if (shadow_free[k] && found < CHAIN_LEN) begin
          picks[found] = k;
          found++;
        end
      end
      if (found < CHAIN_LEN) begin
        r.status = ST_NOSPACE;
      end else begin
        for (int k = 0; k < CHAIN_LEN; k++) shadow_free[picks[k]] = 1'b0;
        shadow_link[picks[0]] = LINK_W'(picks[1]);
        shadow_more[picks[0]] = 1'b1;
        shadow_link[picks[1]] = LINK_W'(picks[2]);
        shadow_more[picks[1]] = 1'b1;
        shadow_link[picks[2]] = '0;
        shadow_more[picks[2]] = 1'b0;
        shadow_in_use += CHAIN_LEN;
        r.first_entry  = LINK_W'(picks[0]);
        r.second_entry = LINK_W'(picks[1]);
        r.third_entry  = LINK_W'(picks[2]);
      end
    end else begin
      cur  = head;
      done = 1'b0;
      while (!done) begin
        if (cur >= POOL_ENTRIES) begin
          r.status = ST_RANGE;
          done = 1'b1;
        end else if (shadow_free[cur]) begin
          r.status = ST_DOUBLE;
          done = 1'b1;
        end else begin
          more = shadow_more[cur];
          nxt  = shadow_link[cur];
          shadow_free[cur] = 1'b1;
          shadow_link[cur] = '0;
          shadow_more[cur] = 1'b0;
          if (shadow_in_use > 0) shadow_in_use--;
          freed++;
          if (!more) begin
            done = 1'b1;
          end else begin
            cur = nxt;
            // A loop in the links would be caught here, though a double free
            // normally ends it first.
            if (freed > POOL_ENTRIES) begin
              r.status = ST_TOOLONG;
              done = 1'b1;
            end
          end
        end
      end
    end
    r.freed_count  = COUNT_W'(freed);
    r.in_use_count = COUNT_W'(shadow_in_use);
    r.peak_in_use  = COUNT_W'(shadow_peak);
    return r;
  endfunction

  // Offer one request and hold it until the block takes it; valid stays high
  // afterwards so back-to-back requests need no second assignment.
  task automatic send_request(opcode_t op, logic [HEAD_W-1:0] head);
    pool_reply_t r;
    req.valid      <= 1'b1;
    req.opcode     <= op;
    req.head_index <= head;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    r = pool_reply(op, head);
    replies_due.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) live_heads.push_back(r.first_entry);
  endtask

  // Drop valid for a random burst now and then, while gaps are enabled.
  task automatic pause_sender();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Pick the next random request. Most are well-formed: allocate while room
  // remains, or free the head of a chain that is still live. The rest are
  // noise: any opcode, any head, including out-of-range and stale ones.
  task automatic pick_request(output opcode_t op, output logic [HEAD_W-1:0] head);
    int free_n;
    int slot;
    free_n = 0;
    for (int k = 0; k < POOL_ENTRIES; k++) free_n += shadow_free[k];
    // Drop heads whose entry has been released in the meantime.
    for (int k = live_heads.size() - 1; k >= 0; k--) begin
      if (shadow_free[live_heads[k]]) live_heads.delete(k);
    end
    head = HEAD_W'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 75) begin
      if (live_heads.size() == 0 || (free_n >= CHAIN_LEN && $urandom_range(0, 1) == 1)) begin
        op = OP_ALLOC;
      end else begin
        op   = OP_FREE;
        slot = $urandom_range(0, live_heads.size() - 1);
        head = HEAD_W'(live_heads[slot]);
        live_heads.delete(slot);
      end
    end else begin
      op = $urandom_range(0, 1) ? OP_FREE : OP_ALLOC;
      if (op == OP_FREE && $urandom_range(0, 1) == 1) head = HEAD_W'($urandom_range(0, 7));
    end
  endtask

  // Receiver: stall in random bursts, or hold off for a long counted stretch
  // when asked, so the block fills and stops taking requests.
  initial begin
    forever begin
      if (hold_request) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Check every reply transfer against the oldest outstanding prediction.
  always @(posedge clk) begin
    pool_reply_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        $error("reply transfer with no request outstanding");
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        compare_field("status",       8'(want.status),       8'(rsp.status));
        compare_field("first_entry",  8'(want.first_entry),  8'(rsp.first_entry));
        compare_field("second_entry", 8'(want.second_entry), 8'(rsp.second_entry));
        compare_field("third_entry",  8'(want.third_entry),  8'(rsp.third_entry));
        compare_field("freed_count",  8'(want.freed_count),  8'(rsp.freed_count));
        compare_field("in_use_count", 8'(want.in_use_count), 8'(rsp.in_use_count));
        compare_field("peak_in_use",  8'(want.peak_in_use),  8'(rsp.peak_in_use));
      end
    end
  end

  // Fill the pool, overrun it, then release whole chains and reuse the space.
  task automatic test_alloc_and_free();
    send_request(OP_ALLOC, 4'hF);  // head is ignored on allocate
    pause_sender();
    send_request(OP_ALLOC, 4'h0);
    pause_sender();
    send_request(OP_ALLOC, 4'h5);  // two entries left: no space, peak sampled
    pause_sender();
    send_request(OP_FREE, 4'h3);   // release the second chain whole
    pause_sender();
    send_request(OP_ALLOC, 4'hA);  // takes the released entries back
    pause_sender();
    send_request(OP_FREE, 4'h0);
    pause_sender();
    send_request(OP_FREE, 4'h3);
    pause_sender();
  endtask

  // Every way a free can stop early.
  task automatic test_bad_frees();
    send_request(OP_FREE, 4'h3);   // already free
    send_request(OP_FREE, 4'h8);   // first index past the pool
    send_request(OP_FREE, 4'hF);   // every head bit set
    send_request(OP_FREE, 4'h7);   // never allocated
    send_request(OP_ALLOC, 4'h0);
    send_request(OP_FREE, 4'h1);   // start mid-chain: frees the tail only
    send_request(OP_FREE, 4'h0);   // head then runs into the freed middle
    send_request(OP_ALLOC, 4'h0);
    send_request(OP_FREE, 4'h2);   // last link alone
    send_request(OP_ALLOC, 4'h0);  // reuses the hole, so old links cross chains
    send_request(OP_FREE, 4'h0);   // walk follows a stale link into a live chain
    send_request(OP_FREE, 4'h6);
    send_request(OP_ALLOC, 4'h0);
    pause_sender();
  endtask

  // Hold the receiver off while requests keep coming, so input stalls.
  task automatic test_backpressure(int count);
    opcode_t           op;
    logic [HEAD_W-1:0] head;
    hold_request = 1'b1;
    for (int n = 0; n < count; n++) begin
      pick_request(op, head);
      send_request(op, head);
    end
  endtask

  task automatic test_random_traffic(int count);
    opcode_t           op;
    logic [HEAD_W-1:0] head;
    for (int n = 0; n < count; n++) begin
      // Switch at random between stretches with and without gaps on both sides.
      if (n % 60 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      pick_request(op, head);
      send_request(op, head);
      pause_sender();
    end
  endtask

  // Closing stretch at full rate: no gaps on either side.
  task automatic test_streaming(int count);
    opcode_t           op;
    logic [HEAD_W-1:0] head;
    gaps_on = 1'b0;
    for (int n = 0; n < count; n++) begin
      pick_request(op, head);
      send_request(op, head);
    end
  endtask

  initial begin
    mismatches   = 0;
    gaps_on      = 1'b1;
    hold_request = 1'b0;
    for (int k = 0; k < POOL_ENTRIES; k++) begin
      shadow_free[k] = 1'b1;
      shadow_link[k] = '0;
      shadow_more[k] = 1'b0;
    end
    shadow_in_use = 0;
    shadow_peak   = 0;

    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.opcode     <= OP_ALLOC;
    req.head_index <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_alloc_and_free();
    test_bad_frees();
    test_backpressure(30);
    test_random_traffic(700);
    test_streaming(150);

    req.valid <= 1'b0;
    // Drain: wait for every outstanding reply, then leave room for strays.
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("descriptor_chain_pool regression: pass");
    end else begin
      $display("descriptor_chain_pool regression: fail");
    end
    $finish;
  end

endmodule
